// ----- hw/rtl/tcae_pkg.sv -----
// Package for the two-color attribute encoder.
// Holds the pixel, pipeline payload and configuration types and the register indexes.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package tcae_pkg;

	localparam int unsigned NumPixels = 8;
	localparam int unsigned PixelWidth = 8;
	localparam int unsigned CfgIndexWidth = 2;

	typedef logic [PixelWidth-1:0] pixel_t;
	typedef pixel_t [NumPixels-1:0] pixel_row_t;

	// Register indexes of the configuration port.
	localparam logic [CfgIndexWidth-1:0] REG_NIBBLE_MODE = 2'd0;
	localparam logic [CfgIndexWidth-1:0] REG_FILL_EMPTY_MASK = 2'd1;
	localparam logic [CfgIndexWidth-1:0] REG_FILL_PATTERN = 2'd2;

	localparam pixel_t FILL_PATTERN_RESET = 8'h33;

	typedef struct packed {
		logic nibble_mode;
		logic fill_empty_mask;
		pixel_t fill_pattern;
	} cfg_t;

	// One group on its way through the scan: the pixels and the two colors.
	typedef struct packed {
		pixel_row_t px;
		pixel_t fg;
		pixel_t bg;
	} group_t;

	// Colors after ordering, with the equal-colors flag.
	typedef struct packed {
		pixel_row_t px;
		pixel_t hi;
		pixel_t lo;
		logic equal;
	} ordered_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcae_unpack.sv -----
// First pipeline stage: unpacks raw bytes into eight pixels and holds the background register.
// Depends on tcae_pkg.
`default_nettype none

module tcae_unpack (
	input wire logic clk,
	input wire logic arst_n,
	input wire tcae_pkg::cfg_t cfg,
	input wire logic up_valid,
	output logic up_ready,
	input wire logic image_start,
	input wire tcae_pkg::pixel_row_t raw,
	output logic down_valid,
	input wire logic down_ready,
	output tcae_pkg::group_t down_data
);

	tcae_pkg::pixel_row_t px;
	tcae_pkg::pixel_t bg_q;
	logic valid_s1;
	tcae_pkg::group_t data_s1;
	logic accept;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (cfg.nibble_mode) begin
				px[2*k] = {4'h0, raw[k][7:4]};
				px[2*k+1] = {4'h0, raw[k][3:0]};
			end else begin
				px[2*k] = raw[2*k];
				px[2*k+1] = raw[2*k+1];
			end
		end
	end

	assign up_ready = !valid_s1 || down_ready;
	assign accept = up_valid && up_ready;

	// The background only changes at the first group of an image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= '0;
		end else if (accept && image_start) begin
			bg_q <= px[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.px <= px;
			data_s1.fg <= px[0];
			data_s1.bg <= image_start ? px[0] : bg_q;
		end
	end

	assign down_valid = valid_s1;
	assign down_data = data_s1;

endmodule

`default_nettype wire

// ----- hw/rtl/tcae_scan.sv -----
// Scan stages: replaces the background by any pixel that matches neither color.
// Pixels one to four are scanned in the first stage, five to seven in the second. Uses tcae_pkg.
`default_nettype none

module tcae_scan (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic up_valid,
	output logic up_ready,
	input wire tcae_pkg::group_t up_data,
	output logic down_valid,
	input wire logic down_ready,
	output tcae_pkg::group_t down_data
);

	logic valid_s2, valid_s3;
	logic ready_s2, ready_s3;
	tcae_pkg::group_t data_s2, data_s3;
	tcae_pkg::pixel_t bg_a, bg_b;

	// Pixel zero is the foreground itself and never changes the background.
	always_comb begin
		bg_a = up_data.bg;
		for (int i = 1; i <= 4; i++) begin
			if (up_data.px[i] != up_data.fg && up_data.px[i] != bg_a) begin
				bg_a = up_data.px[i];
			end
		end
	end

	always_comb begin
		bg_b = data_s2.bg;
		for (int i = 5; i < tcae_pkg::NumPixels; i++) begin
			if (data_s2.px[i] != data_s2.fg && data_s2.px[i] != bg_b) begin
				bg_b = data_s2.px[i];
			end
		end
	end

	assign ready_s3 = !valid_s3 || down_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= up_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && up_valid) begin
			data_s2.px <= up_data.px;
			data_s2.fg <= up_data.fg;
			data_s2.bg <= bg_a;
		end
		if (ready_s3 && valid_s2) begin
			data_s3.px <= data_s2.px;
			data_s3.fg <= data_s2.fg;
			data_s3.bg <= bg_b;
		end
	end

	assign down_valid = valid_s3;
	assign down_data = data_s3;

endmodule

`default_nettype wire

// ----- hw/rtl/tcae_mask.sv -----
// Output stages: orders the two colors, then builds the color and mask bytes.
// The last stage is the output register. Uses tcae_pkg.
`default_nettype none

module tcae_mask (
	input wire logic clk,
	input wire logic arst_n,
	input wire tcae_pkg::cfg_t cfg,
	input wire logic up_valid,
	output logic up_ready,
	input wire tcae_pkg::group_t up_data,
	output logic down_valid,
	input wire logic down_ready,
	output tcae_pkg::pixel_t color_byte,
	output tcae_pkg::pixel_t mask_byte
);

	logic valid_s4, valid_s5;
	logic ready_s4, ready_s5;
	tcae_pkg::ordered_t data_s4;
	tcae_pkg::pixel_t color_s5, mask_s5;
	tcae_pkg::pixel_t mask_raw, mask_out;
	logic fg_larger;

	assign fg_larger = up_data.fg > up_data.bg;

	always_comb begin
		mask_raw = '0;
		for (int i = 0; i < tcae_pkg::NumPixels; i++) begin
			mask_raw[tcae_pkg::NumPixels-1-i] = (data_s4.px[i] == data_s4.hi);
		end
		if (data_s4.equal) begin
			mask_raw = '0;
		end
		mask_out = (mask_raw == '0 && cfg.fill_empty_mask) ? cfg.fill_pattern : mask_raw;
	end

	assign ready_s5 = !valid_s5 || down_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign up_ready = ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s4) begin
				valid_s4 <= up_valid;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && up_valid) begin
			data_s4.px <= up_data.px;
			data_s4.hi <= fg_larger ? up_data.fg : up_data.bg;
			data_s4.lo <= fg_larger ? up_data.bg : up_data.fg;
			data_s4.equal <= (up_data.fg == up_data.bg);
		end
		if (ready_s5 && valid_s4) begin
			color_s5 <= {data_s4.hi[3:0], 4'h0} | data_s4.lo;
			mask_s5 <= mask_out;
		end
	end

	assign down_valid = valid_s5;
	assign color_byte = color_s5;
	assign mask_byte = mask_s5;

endmodule

`default_nettype wire

// ----- hw/rtl/two_color_attribute_encoder_core.sv -----
// Two-color attribute encoder: one group of eight pixels in, one color and mask byte out.
// Throughput is one item per cycle when the result side does not stall.
// The five stages are unpack, two scan stages, color ordering, and mask build with output register.
// Reset is asynchronous and active low: it empties the pipeline, clears the background to zero
// and returns the configuration registers to 8-bit mode, no fill, fill pattern 0x33.
`default_nettype none

module two_color_attribute_encoder_core (
	input wire logic clk,
	input wire logic arst_n,
	// Configuration write channel.
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [tcae_pkg::CfgIndexWidth-1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	// Pixel group input channel.
	input wire logic item_valid,
	output logic item_ready,
	input wire logic image_start,
	input wire logic [7:0] byte_0,
	input wire logic [7:0] byte_1,
	input wire logic [7:0] byte_2,
	input wire logic [7:0] byte_3,
	input wire logic [7:0] byte_4,
	input wire logic [7:0] byte_5,
	input wire logic [7:0] byte_6,
	input wire logic [7:0] byte_7,
	// Result channel.
	output logic result_valid,
	input wire logic result_ready,
	output logic [7:0] color_byte,
	output logic [7:0] mask_byte
);

	tcae_pkg::cfg_t cfg_q;
	tcae_pkg::pixel_row_t raw;
	logic unp_valid, unp_ready;
	tcae_pkg::group_t unp_data;
	logic scan_valid, scan_ready;
	tcae_pkg::group_t scan_data;

	// Configuration writes are always taken. Indexes beyond the register list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nibble_mode <= 1'b0;
			cfg_q.fill_empty_mask <= 1'b0;
			cfg_q.fill_pattern <= tcae_pkg::FILL_PATTERN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tcae_pkg::REG_NIBBLE_MODE: begin
					cfg_q.nibble_mode <= cfg_data[0];
				end
				tcae_pkg::REG_FILL_EMPTY_MASK: begin
					cfg_q.fill_empty_mask <= cfg_data[0];
				end
				tcae_pkg::REG_FILL_PATTERN: begin
					cfg_q.fill_pattern <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign raw = {byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};

	// Stage one: pixel unpacking and the background register. Every stage stalls
	// independently, so a bubble is squeezed out as soon as the next stage is free.
	tcae_unpack u_unpack (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg_q),
		.up_valid (item_valid),
		.up_ready (item_ready),
		.image_start (image_start),
		.raw (raw),
		.down_valid (unp_valid),
		.down_ready (unp_ready),
		.down_data (unp_data)
	);

	// Stages two and three: the background replacement scan, split between them.
	tcae_scan u_scan (
		.clk (clk),
		.arst_n (arst_n),
		.up_valid (unp_valid),
		.up_ready (unp_ready),
		.up_data (unp_data),
		.down_valid (scan_valid),
		.down_ready (scan_ready),
		.down_data (scan_data)
	);

	// Stages four and five: color ordering, mask build and the output register.
	tcae_mask u_mask (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg_q),
		.up_valid (scan_valid),
		.up_ready (scan_ready),
		.up_data (scan_data),
		.down_valid (result_valid),
		.down_ready (result_ready),
		.color_byte (color_byte),
		.mask_byte (mask_byte)
	);

endmodule

`default_nettype wire

// ----- sim/tcae_attr_checker.sv -----
// Scoreboard for the two-color attribute encoder: watches the configuration, item and result
// channels, predicts each color and mask byte, and compares them in order.
// Depends on tcae_pkg for the pixel, row and configuration types and the register indexes.

module tcae_attr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [tcae_pkg::CfgIndexWidth-1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic item_valid,
	input wire logic item_ready,
	input wire logic image_start,
	input wire logic [7:0] byte_0,
	input wire logic [7:0] byte_1,
	input wire logic [7:0] byte_2,
	input wire logic [7:0] byte_3,
	input wire logic [7:0] byte_4,
	input wire logic [7:0] byte_5,
	input wire logic [7:0] byte_6,
	input wire logic [7:0] byte_7,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic [7:0] color_byte,
	input wire logic [7:0] mask_byte,
	output int fail_count,
	output int pending
);

	typedef struct packed {
		logic [7:0] color;
		logic [7:0] mask;
	} attr_t;

	tcae_pkg::cfg_t cfg_shadow;
	tcae_pkg::pixel_t bg_shadow;
	tcae_pkg::pixel_row_t raw_row;
	tcae_pkg::pixel_row_t px_row;
	tcae_pkg::pixel_t bg_used;
	attr_t attr_queue[$];
	attr_t attr_got;
	attr_t attr_want;

	assign raw_row = {byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// In nibble mode the first four bytes each hold two pixels, high nibble first.
	function automatic tcae_pkg::pixel_row_t unpack_group(input logic nib,
			input tcae_pkg::pixel_row_t raw);
		tcae_pkg::pixel_row_t px;
		px = raw;
		if (nib) begin
			for (int k = 0; k < 4; k++) begin
				px[2*k] = {4'h0, raw[k][7:4]};
				px[2*k+1] = {4'h0, raw[k][3:0]};
			end
		end
		return px;
	endfunction

	function automatic attr_t encode_attr(input tcae_pkg::pixel_row_t px,
			input tcae_pkg::pixel_t bg_in, input tcae_pkg::cfg_t cfg);
		tcae_pkg::pixel_t fg;
		tcae_pkg::pixel_t bg;
		tcae_pkg::pixel_t hi;
		tcae_pkg::pixel_t lo;
		logic [7:0] mask;
		fg = px[0];
		bg = bg_in;
		for (int i = 0; i < 8; i++) begin
			if (px[i] != fg && px[i] != bg)
				bg = px[i];
		end
		hi = (fg > bg) ? fg : bg;
		lo = (fg > bg) ? bg : fg;
		mask = '0;
		if (fg != bg) begin
			for (int i = 0; i < 8; i++) begin
				if (px[i] == hi)
					mask[7-i] = 1'b1;
			end
		end
		if (mask == '0 && cfg.fill_empty_mask)
			mask = cfg.fill_pattern;
		return {({hi[3:0], 4'h0} | lo), mask};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_shadow <= '{nibble_mode: 1'b0, fill_empty_mask: 1'b0,
				fill_pattern: tcae_pkg::FILL_PATTERN_RESET};
			bg_shadow <= '0;
			attr_queue.delete();
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				attr_got = {color_byte, mask_byte};
				if (attr_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected result color %02h mask %02h",
						color_byte, mask_byte));
				end else begin
					attr_want = attr_queue.pop_front();
					if (attr_got.color !== attr_want.color)
						report_mismatch($sformatf("color_byte expected %02h got %02h",
							attr_want.color, attr_got.color));
					if (attr_got.mask !== attr_want.mask)
						report_mismatch($sformatf("mask_byte expected %02h got %02h",
							attr_want.mask, attr_got.mask));
				end
			end
			if (item_valid && item_ready) begin
				px_row = unpack_group(cfg_shadow.nibble_mode, raw_row);
				bg_used = image_start ? px_row[0] : bg_shadow;
				bg_shadow <= bg_used;
				attr_queue.push_back(encode_attr(px_row, bg_used, cfg_shadow));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tcae_pkg::REG_NIBBLE_MODE: cfg_shadow.nibble_mode <= cfg_data[0];
					tcae_pkg::REG_FILL_EMPTY_MASK: cfg_shadow.fill_empty_mask <= cfg_data[0];
					tcae_pkg::REG_FILL_PATTERN: cfg_shadow.fill_pattern <= cfg_data;
					default: ;
				endcase
			end
			pending <= attr_queue.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
// Top of the two-color attribute encoder testbench: clock, reset, stimulus and verdict.
// Depends on tcae_pkg, the encoder core and tcae_attr_checker, which does all the checking.

module tb_top;

	// Worst case is far below this: about 1300 items, each with a gap and a result stall,
	// plus the pipeline latency and the drains between phases.
	localparam int CycleLimit = 400000;
	localparam int ItemsPerPhase = 155;
	localparam int NumPhases = 8;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [tcae_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [7:0] cfg_data;
	logic item_valid;
	logic item_ready;
	logic image_start;
	tcae_pkg::pixel_row_t grp_bytes;
	logic result_valid;
	logic result_ready;
	logic [7:0] color_byte;
	logic [7:0] mask_byte;
	int fail_count;
	int pending;

	// Stimulus knobs. The percentages give the chance that an item is preceded by a gap, or
	// that a cycle starts a stall burst on the result side.
	int gap_pct;
	int stall_pct;
	int stall_left;
	int cycles;
	logic nibble_on;
	tcae_pkg::pixel_t palette[4];

	two_color_attribute_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.image_start(image_start),
		.byte_0(grp_bytes[0]),
		.byte_1(grp_bytes[1]),
		.byte_2(grp_bytes[2]),
		.byte_3(grp_bytes[3]),
		.byte_4(grp_bytes[4]),
		.byte_5(grp_bytes[5]),
		.byte_6(grp_bytes[6]),
		.byte_7(grp_bytes[7]),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.color_byte(color_byte),
		.mask_byte(mask_byte)
	);

	tcae_attr_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.image_start(image_start),
		.byte_0(grp_bytes[0]),
		.byte_1(grp_bytes[1]),
		.byte_2(grp_bytes[2]),
		.byte_3(grp_bytes[3]),
		.byte_4(grp_bytes[4]),
		.byte_5(grp_bytes[5]),
		.byte_6(grp_bytes[6]),
		.byte_7(grp_bytes[7]),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.color_byte(color_byte),
		.mask_byte(mask_byte),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #10 clk = ~clk;

	// The watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side back-pressure. A burst holds ready low; with stall_pct at zero the receiver
	// always takes the result at once.
	initial begin
		result_ready = 1'b1;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 13);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Presents one item at the current falling edge and holds it until it is taken. The task
	// returns at a falling edge with valid still high, so a following item goes out back to back.
	task automatic send_group(input logic start, input tcae_pkg::pixel_row_t bytes);
		item_valid <= 1'b1;
		image_start <= start;
		grp_bytes <= bytes;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
	endtask

	task automatic maybe_gap();
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
	endtask

	// Waits until every expected result has come back, then lets the pipeline settle.
	task automatic drain();
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [tcae_pkg::CfgIndexWidth-1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Only the low bit of the two mode registers matters; the upper bits are random so that
	// every bit of the write data is exercised.
	task automatic configure(input logic nib, input logic fill, input logic [7:0] pattern);
		drain();
		write_reg(tcae_pkg::REG_NIBBLE_MODE, {7'($urandom), nib});
		write_reg(tcae_pkg::REG_FILL_EMPTY_MASK, {7'($urandom), fill});
		write_reg(tcae_pkg::REG_FILL_PATTERN, pattern);
		nibble_on = nib;
	endtask

	// Each image draws its groups from a small palette, so that backgrounds carry over between
	// groups and masks are neither all set nor all clear. Extremes are put in now and then.
	task automatic new_palette();
		for (int i = 0; i < 4; i++)
			palette[i] = 8'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			palette[0] = 8'h00;
			palette[1] = 8'hff;
		end
		if (nibble_on) begin
			for (int i = 0; i < 4; i++)
				palette[i] = {4'h0, palette[i][3:0]};
		end
	endtask

	function automatic tcae_pkg::pixel_row_t build_group();
		tcae_pkg::pixel_row_t px;
		tcae_pkg::pixel_row_t bytes;
		tcae_pkg::pixel_t pick[3];
		int ncol;
		int r;
		// One group in ten is plain noise: random bytes in every position.
		if ($urandom_range(0, 9) == 0)
			return {$urandom, $urandom};
		r = $urandom_range(0, 9);
		ncol = (r < 2) ? 1 : (r < 8) ? 2 : 3;
		for (int i = 0; i < 3; i++)
			pick[i] = palette[$urandom_range(0, 3)];
		for (int i = 0; i < 8; i++)
			px[i] = pick[$urandom_range(0, ncol - 1)];
		if (nibble_on) begin
			// Pack two pixels per byte; the upper four bytes are ignored and carry noise.
			for (int k = 0; k < 4; k++)
				bytes[k] = {px[2*k][3:0], px[2*k+1][3:0]};
			for (int k = 4; k < 8; k++)
				bytes[k] = 8'($urandom);
		end else begin
			bytes = px;
		end
		return bytes;
	endfunction

	initial begin
		logic start;
		logic [7:0] pattern;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		image_start = 1'b0;
		grp_bytes = '0;
		nibble_on = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset configuration: 8-bit pixels, no fill. The first two groups come
		// before any image start, so they are encoded against the reset background of zero.
		send_group(1'b0, '0);
		send_group(1'b0, {8{8'hff}});
		// Equal wide colors: the color byte keeps only the low nibble of the shifted max.
		send_group(1'b1, {8{8'hff}});
		// Several pixels that match neither color, so the background is replaced mid-scan.
		send_group(1'b1, {8'h00, 8'h12, 8'h56, 8'h34, 8'hff, 8'h12, 8'h34, 8'h12});
		send_group(1'b0, {8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00});
		send_group(1'b0, {8'h3c, 8'ha5, 8'ha5, 8'h3c, 8'h3c, 8'ha5, 8'h3c, 8'ha5});

		// Nibble mode with an empty-mask fill of all zeros. The ignored upper bytes hold noise.
		configure(1'b1, 1'b1, 8'h00);
		send_group(1'b1, {8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00});
		send_group(1'b0, {8'h5a, 8'hc3, 8'h81, 8'h7e, 8'hf0, 8'hf0, 8'hf0, 8'hf0});
		send_group(1'b1, {8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff});

		configure(1'b1, 1'b1, 8'hff);
		send_group(1'b1, {8'h12, 8'h34, 8'h56, 8'h78, 8'h77, 8'h77, 8'h77, 8'h77});
		send_group(1'b0, {8'h00, 8'h00, 8'h00, 8'h00, 8'hc3, 8'h3c, 8'ha5, 8'h5a});

		// Back to 8-bit pixels with the default fill pattern: an equal-color group gets filled.
		configure(1'b0, 1'b1, 8'h33);
		send_group(1'b1, {8{8'h80}});
		send_group(1'b0, {8'h80, 8'h7f, 8'h80, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'h80});

		// Random phases. Each phase sets its own configuration, including the extremes of the
		// fill pattern, and its own idling: none, light or heavy. The last phase has none.
		for (int ph = 0; ph < NumPhases; ph++) begin
			pattern = (ph == 2) ? 8'h00 : (ph == 3) ? 8'hff : 8'($urandom);
			configure(ph[0], ph[1], pattern);
			if (ph == NumPhases - 1 || ph % 3 == 0) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if (ph % 3 == 1) begin
				gap_pct = 10;
				stall_pct = 5;
			end else begin
				gap_pct = 30;
				stall_pct = 20;
			end
			new_palette();
			send_group(1'b1, build_group());
			for (int n = 1; n < ItemsPerPhase; n++) begin
				maybe_gap();
				start = ($urandom_range(0, 19) == 0);
				if (start)
					new_palette();
				send_group(start, build_group());
			end
		end

		// Everything has been sent; wait for the last results, then let the pipeline settle.
		drain();
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/tcae_pkg.sv
hw/rtl/tcae_unpack.sv
hw/rtl/tcae_scan.sv
hw/rtl/tcae_mask.sv
hw/rtl/two_color_attribute_encoder_core.sv
sim/tcae_attr_checker.sv
sim/tb_top.sv
